// ===== hw/rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the stream duplicate filter: the field
// widths, the item kind codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned VALUE_W = 32;

  // Item kind codes.
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming value and restart the scan
    logic clear;   // empty the store
    logic scan;    // advance the store scan by one entry
    logic commit;  // present the result and append the value if room remains
  } sdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every stored entry compared, or a match found
    logic match;      // the held value equals a stored entry
    logic out_free;   // the result register can take a new beat
  } sdf_status_t;

endpackage

// ===== hw/rtl/stream_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// stream_duplicate_filter
// Passes on the first occurrence of each 32-bit value and drops repeats.
// ----------------------------------------------------------------------------
// Each value beat is compared against the stored entries, read from a
// single-port-read RAM one entry per cycle; a repeat ends the scan early.
// A clear beat empties the store and produces no result. New values are
// appended until STORE_DEPTH entries are held; after that they come out with
// store_full set and are not remembered. The result register lets the next
// beat be accepted while a result waits to be taken.
module stream_duplicate_filter
  import sdf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      kind,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] unique_value,
  output logic                      store_full
);

  sdf_cmd_t    cmd;
  sdf_status_t status;

  sdf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .kind       (kind),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  sdf_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .unique_value (unique_value),
    .store_full   (store_full)
  );

endmodule

// ===== hw/rtl/sdf_ram.sv =====
// ----------------------------------------------------------------------------
// sdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdf_ctrl
// Controller for the stream duplicate filter: accepts items, runs the store
// scan and hands the decision to the datapath.
// ----------------------------------------------------------------------------
module sdf_ctrl
  import sdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        kind,
  output logic        item_stall,
  input  sdf_status_t status,
  output sdf_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (kind == KIND_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = status.match ? ST_IDLE : ST_WRITE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/sdf_datapath.sv =====
// ----------------------------------------------------------------------------
// sdf_datapath
// Datapath for the stream duplicate filter: the seen-value store, the fill
// count, the scan comparator and the result register.
// ----------------------------------------------------------------------------
module sdf_datapath
  import sdf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64,
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sdf_cmd_t                  cmd,
  output sdf_status_t               status,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] unique_value,
  output logic                      store_full
);

  logic [VALUE_W-1:0] item_value;
  logic [CW-1:0]      count;
  logic [CW-1:0]      scan_idx;
  logic               cmp_pending;
  logic               match;
  logic               issue;
  logic               hit;
  logic               full;
  logic               wr_en;
  logic [VALUE_W-1:0] rd_data;

  assign full  = (count == CW'(STORE_DEPTH));
  assign issue = cmd.scan && (scan_idx != count) && !match;
  // The RAM read is registered, so a read issued in one cycle is compared
  // in the next.
  assign hit   = cmp_pending && (rd_data == item_value);
  assign wr_en = cmd.commit && !full;

  assign status.scan_done = !cmp_pending && ((scan_idx == count) || match);
  assign status.match     = match;
  assign status.out_free  = !result_valid || !result_stall;

  sdf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (item_value),
    .rd_en   (issue),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      scan_idx     <= '0;
      cmp_pending  <= 1'b0;
      match        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CW'(1);
      end

      if (cmd.load) begin
        scan_idx    <= '0;
        cmp_pending <= 1'b0;
        match       <= 1'b0;
      end else begin
        cmp_pending <= issue;
        if (issue) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (hit) begin
          match <= 1'b1;
        end
      end

      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_value <= value;
    end
    if (cmd.commit) begin
      unique_value <= item_value;
      store_full   <= full;
    end
  end

endmodule
